>>> sv/mbrtu_pkg.sv
// Shared types, codes and the CRC-16 step for the Modbus RTU request framer.
// No dependencies; used by the front end, queue, back end and top level.
package mbrtu_pkg;

	// request kinds on the input channel
	localparam logic [1:0] KIND_READ_INPUT   = 2'd0;
	localparam logic [1:0] KIND_READ_HOLDING = 2'd1;
	localparam logic [1:0] KIND_WRITE_HOLD   = 2'd2;

	// Modbus function codes
	localparam logic [7:0] FUNC_READ_INPUT   = 8'h04;
	localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
	localparam logic [7:0] FUNC_WRITE_MULTI  = 8'h10;

	// fixed frame contents
	localparam logic [7:0] REG_COUNT_HI  = 8'h00;
	localparam logic [7:0] REG_COUNT_LO  = 8'h02;
	localparam logic [7:0] WR_BYTE_COUNT = 8'h04;
	localparam logic [7:0] NODE_ID_RESET = 8'h01;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// byte positions inside a frame
	localparam int FRAME_IDX_W = 4;
	localparam logic [FRAME_IDX_W-1:0] POS_NODE     = 4'd0;
	localparam logic [FRAME_IDX_W-1:0] POS_FUNC     = 4'd1;
	localparam logic [FRAME_IDX_W-1:0] POS_ADDR_HI  = 4'd2;
	localparam logic [FRAME_IDX_W-1:0] POS_ADDR_LO  = 4'd3;
	localparam logic [FRAME_IDX_W-1:0] POS_CNT_HI   = 4'd4;
	localparam logic [FRAME_IDX_W-1:0] POS_CNT_LO   = 4'd5;
	localparam logic [FRAME_IDX_W-1:0] POS_BYTE_CNT = 4'd6;
	localparam logic [FRAME_IDX_W-1:0] POS_VAL_3    = 4'd7;
	localparam logic [FRAME_IDX_W-1:0] POS_VAL_2    = 4'd8;
	localparam logic [FRAME_IDX_W-1:0] POS_VAL_1    = 4'd9;
	localparam logic [FRAME_IDX_W-1:0] POS_VAL_0    = 4'd10;

	// bytes covered by the CRC
	localparam logic [FRAME_IDX_W-1:0] READ_DATA_LEN  = 4'd6;
	localparam logic [FRAME_IDX_W-1:0] WRITE_DATA_LEN = 4'd11;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [7:0]  node;
		logic [7:0]  func;
		logic        is_write;
		logic [15:0] addr;
		logic [31:0] value;
	} req_t;

	// one byte through the reflected CRC-16
	function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
		input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

>>> sv/mbrtu_front.sv
// Front end: node id register, request decode and drop of the unused kind.
// Depends on mbrtu_pkg.
module mbrtu_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [7:0]           node_id,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           kind,
	input  logic [15:0]          reg_address,
	input  logic [31:0]          write_value,
	input  logic                 q_full,
	output logic                 q_push,
	output mbrtu_pkg::req_t      q_data
);

	logic [7:0] node_id_q;
	logic       kind_ok;
	logic [7:0] func;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q <= mbrtu_pkg::NODE_ID_RESET;
		end else if (cfg_valid && cfg_ready) begin
			node_id_q <= node_id;
		end
	end

	assign cfg_ready = 1'b1;

	always_comb begin
		kind_ok = 1'b1;
		case (kind)
			mbrtu_pkg::KIND_READ_INPUT:   func = mbrtu_pkg::FUNC_READ_INPUT;
			mbrtu_pkg::KIND_READ_HOLDING: func = mbrtu_pkg::FUNC_READ_HOLDING;
			mbrtu_pkg::KIND_WRITE_HOLD:   func = mbrtu_pkg::FUNC_WRITE_MULTI;
			default: begin
				// meaningless kind: take it and drop it
				func    = mbrtu_pkg::FUNC_READ_INPUT;
				kind_ok = 1'b0;
			end
		endcase
	end

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready && kind_ok;

	always_comb begin
		q_data.node     = node_id_q;
		q_data.func     = func;
		q_data.is_write = (kind == mbrtu_pkg::KIND_WRITE_HOLD);
		q_data.addr     = reg_address;
		q_data.value    = write_value;
	end

endmodule

>>> sv/mbrtu_queue.sv
// Short request queue between the decoder and the byte serializer.
// Depends on mbrtu_pkg.
module mbrtu_queue #(
	parameter int DEPTH = mbrtu_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  mbrtu_pkg::req_t      push_data,
	output logic                 full,
	input  logic                 pop,
	output logic                 head_valid,
	output mbrtu_pkg::req_t      head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

	mbrtu_pkg::req_t mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full       = (cnt_q == FULL_CNT);
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> sv/mbrtu_back.sv
// Back end: walks the queue head's frame one byte per cycle unless the output stalls,
// folds each data byte into the running CRC and appends it. Depends on mbrtu_pkg.
module mbrtu_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  mbrtu_pkg::req_t      head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           frame_byte,
	output logic                 last_byte
);

	localparam int IW = mbrtu_pkg::FRAME_IDX_W;

	logic [IW-1:0] idx_q;
	logic [15:0]   crc_q;
	logic          out_valid_q;
	logic [7:0]    byte_q;
	logic          last_q;

	logic [IW-1:0] data_len;
	logic [7:0]    cur_byte;
	logic          cur_last;
	logic          in_data;
	logic [15:0]   crc_next;
	logic          adv;

	assign adv = head_valid && (!out_valid_q || out_ready);

	always_comb begin
		data_len = head.is_write ? mbrtu_pkg::WRITE_DATA_LEN : mbrtu_pkg::READ_DATA_LEN;
		cur_last = 1'b0;
		case (idx_q)
			mbrtu_pkg::POS_NODE:     cur_byte = head.node;
			mbrtu_pkg::POS_FUNC:     cur_byte = head.func;
			mbrtu_pkg::POS_ADDR_HI:  cur_byte = head.addr[15:8];
			mbrtu_pkg::POS_ADDR_LO:  cur_byte = head.addr[7:0];
			mbrtu_pkg::POS_CNT_HI:   cur_byte = mbrtu_pkg::REG_COUNT_HI;
			mbrtu_pkg::POS_CNT_LO:   cur_byte = mbrtu_pkg::REG_COUNT_LO;
			mbrtu_pkg::POS_BYTE_CNT: cur_byte = mbrtu_pkg::WR_BYTE_COUNT;
			mbrtu_pkg::POS_VAL_3:    cur_byte = head.value[31:24];
			mbrtu_pkg::POS_VAL_2:    cur_byte = head.value[23:16];
			mbrtu_pkg::POS_VAL_1:    cur_byte = head.value[15:8];
			mbrtu_pkg::POS_VAL_0:    cur_byte = head.value[7:0];
			default:                 cur_byte = 8'h00;
		endcase
		// the two trailing bytes carry the CRC, low byte first
		if (idx_q == data_len) begin
			cur_byte = crc_q[7:0];
		end
		if (idx_q == IW'(data_len + 1'b1)) begin
			cur_byte = crc_q[15:8];
			cur_last = 1'b1;
		end
		in_data  = (idx_q < data_len);
		crc_next = mbrtu_pkg::crc16_update(
			(idx_q == mbrtu_pkg::POS_NODE) ? mbrtu_pkg::CRC_INIT : crc_q, cur_byte);
	end

	assign pop = adv && cur_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			crc_q       <= mbrtu_pkg::CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
				idx_q       <= cur_last ? '0 : idx_q + 1'b1;
				if (in_data) begin
					crc_q <= crc_next;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_q <= cur_byte;
			last_q <= cur_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = byte_q;
	assign last_byte  = last_q;

endmodule

>>> sv/modbus_rtu_request_framer.sv
// Modbus RTU request framer: decoder, request queue and byte serializer with CRC-16.
// Throughput: one byte per cycle while out_ready is high; 8 bytes per read frame and 13
// per write frame; frames follow back to back while the queue holds requests.
// Reset (arst_n low) empties the queue and output stage and sets node_id to 1.
// Depends on mbrtu_pkg, mbrtu_front, mbrtu_queue and mbrtu_back.
module modbus_rtu_request_framer #(
	parameter int QUEUE_DEPTH = mbrtu_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  node_id,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [15:0] reg_address,
	input  logic [31:0] write_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  frame_byte,
	output logic        last_byte
);

	mbrtu_pkg::req_t push_data;
	mbrtu_pkg::req_t head;
	logic            push;
	logic            full;
	logic            pop;
	logic            head_valid;

	mbrtu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.node_id     (node_id),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.reg_address (reg_address),
		.write_value (write_value),
		.q_full      (full),
		.q_push      (push),
		.q_data      (push_data)
	);

	mbrtu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	mbrtu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

endmodule

>>> sv/mbrtu_checker.sv
// Port-level checks for the Modbus RTU request framer, bound to the top level.
// Depends only on the top-level ports.
module mbrtu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  frame_byte,
	input logic        last_byte
);

	logic [3:0] bytes_q;
	logic       out_xfer;

	assign out_xfer = out_valid && out_ready;

	// count bytes transferred so far in the current frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q <= '0;
		end else if (out_xfer) begin
			bytes_q <= last_byte ? 4'd0 : bytes_q + 4'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped without a transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(frame_byte) && $stable(last_byte))
		else $error("output payload changed while stalled");

	a_frame_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && last_byte |-> (bytes_q == 4'd7 || bytes_q == 4'd12))
		else $error("frame ended at a length other than 8 or 13 bytes");

	a_frame_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && !last_byte |-> bytes_q < 4'd12)
		else $error("frame ran past 13 bytes without a last byte");

endmodule

bind modbus_rtu_request_framer mbrtu_checker u_mbrtu_checker (.*);
